>>> rtl/aff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aff_pkg
// Shared types and constants for the 3x4 affine inverse pipeline.
// ----------------------------------------------------------------------------
package aff_pkg;

	localparam logic [1:0] ROW_FIRST = 2'd0;
	localparam logic [1:0] ROW_LAST  = 2'd2;

	typedef struct packed {
		logic       vld;
		logic [1:0] row;
		logic       sing;
	} side_t;

endpackage

>>> rtl/aff_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aff_cof
// Cofactor stages: six products for the selected row, then the differences.
// ----------------------------------------------------------------------------
module aff_cof #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aff_pkg::side_t        side_i,
	input  logic signed [W-1:0]   m [3][3],
	input  logic signed [W-1:0]   t [3],
	output aff_pkg::side_t        side_o,
	output logic signed [2*W:0]   adj_o [3],
	output logic signed [W-1:0]   mcol_o [3],
	output logic signed [W-1:0]   t_o [3]
);

	logic [1:0] r1, r2;
	logic signed [2*W-1:0] p_s2 [3];
	logic signed [2*W-1:0] q_s2 [3];
	logic signed [W-1:0]   mcol_s2 [3];
	logic signed [W-1:0]   t_s2 [3];
	aff_pkg::side_t        side_s2, side_s3;

	always_comb begin
		case (side_i.row)
			2'd0: begin r1 = 2'd1; r2 = 2'd2; end
			2'd1: begin r1 = 2'd2; r2 = 2'd0; end
			default: begin r1 = 2'd0; r2 = 2'd1; end
		endcase
	end

	for (genvar c = 0; c < 3; c++) begin : g_col
		localparam int C1 = (c + 1) % 3;
		localparam int C2 = (c + 2) % 3;

		always_ff @(posedge clk) begin
			p_s2[c]    <= m[C1][r1] * m[C2][r2];
			q_s2[c]    <= m[C1][r2] * m[C2][r1];
			mcol_s2[c] <= m[c][side_i.row];
			t_s2[c]    <= t[c];
		end

		always_ff @(posedge clk) begin
			adj_o[c]  <= {p_s2[c][2*W-1], p_s2[c]} - {q_s2[c][2*W-1], q_s2[c]};
			mcol_o[c] <= mcol_s2[c];
			t_o[c]    <= t_s2[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
		end else begin
			side_s2 <= side_i;
			side_s3 <= side_s2;
		end
	end

	assign side_o = side_s3;

endmodule

>>> rtl/aff_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aff_dot
// Row determinant and shift dot product, then numerators and magnitudes.
// ----------------------------------------------------------------------------
module aff_dot #(
	parameter int W  = 32,
	parameter int F  = 16,
	parameter int DW = 3*W + 2,
	parameter int NW = 3*W + 3 + 2*F
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aff_pkg::side_t        side_i,
	input  logic signed [2*W:0]   adj [3],
	input  logic signed [W-1:0]   mcol [3],
	input  logic signed [W-1:0]   t [3],
	output aff_pkg::side_t        side_o,
	output logic [NW-1:0]         num_o [4],
	output logic                  neg_o [4],
	output logic [DW-1:0]         den_o
);

	logic signed [2*W:0] pdl_s4 [3];
	logic signed [2*W:0] pdh_s4 [3];
	logic signed [2*W:0] ptl_s4 [3];
	logic signed [2*W:0] pth_s4 [3];
	logic signed [2*W:0] adj_s4 [3];
	logic signed [2*W:0] adj_s5 [3];
	logic signed [DW-1:0] det_s5, acc_s5, det_sum, acc_sum;
	logic signed [NW-1:0] num [4];
	logic                 dneg;
	aff_pkg::side_t       side_s4, side_s5, side_s6;

	for (genvar c = 0; c < 3; c++) begin : g_prod
		logic signed [W:0] al, ah;
		assign al = $signed({1'b0, adj[c][W-1:0]});
		assign ah = adj[c][2*W:W];

		always_ff @(posedge clk) begin
			pdl_s4[c] <= al * mcol[c];
			pdh_s4[c] <= ah * mcol[c];
			ptl_s4[c] <= al * t[c];
			pth_s4[c] <= ah * t[c];
			adj_s4[c] <= adj[c];
			adj_s5[c] <= adj_s4[c];
		end
	end

	always_comb begin
		det_sum = '0;
		acc_sum = '0;
		for (int c = 0; c < 3; c++) begin
			det_sum = det_sum + (DW'(pdh_s4[c]) <<< W) + DW'(pdl_s4[c]);
			acc_sum = acc_sum + (DW'(pth_s4[c]) <<< W) + DW'(ptl_s4[c]);
		end
	end

	always_ff @(posedge clk) begin
		det_s5 <= det_sum;
		acc_s5 <= acc_sum;
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num[c] = NW'(adj_s5[c]) <<< (2*F);
		end
		num[3] = (-NW'(acc_s5)) <<< F;
		dneg   = det_s5[DW-1];
	end

	for (genvar k = 0; k < 4; k++) begin : g_num
		always_ff @(posedge clk) begin
			num_o[k] <= num[k][NW-1] ? NW'(-num[k]) : NW'(num[k]);
			neg_o[k] <= num[k][NW-1] ^ dneg;
		end
	end

	always_ff @(posedge clk) begin
		den_o <= dneg ? DW'(-det_s5) : DW'(det_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
			side_s5 <= '0;
			side_s6 <= '0;
		end else begin
			side_s4 <= side_i;
			side_s5 <= side_s4;
			side_s6 <= '{vld: side_s5.vld, row: side_s5.row, sing: (det_s5 == '0)};
		end
	end

	assign side_o = side_s6;

endmodule

>>> rtl/aff_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aff_div
// Pipelined restoring divider, one quotient bit per stage, with saturation and clear.
// ----------------------------------------------------------------------------
module aff_div #(
	parameter int W  = 32,
	parameter int NW = 130,
	parameter int DW = 98
) (
	input  logic                clk,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	input  logic                neg,
	input  logic                clr,
	output logic signed [W-1:0] quo
);

	localparam int UW = NW + W;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic [NW-1:0] rem_sn [W+1];
	logic [DW-1:0] den_sn [W+1];
	logic [W-1:0]  quo_sn [W+1];
	logic          ovf_sn [W+1];
	logic          neg_sn [W+1];
	logic          clr_sn [W+1];
	logic [W-1:0]  mag, res;

	always_ff @(posedge clk) begin
		rem_sn[0] <= num;
		den_sn[0] <= den;
		quo_sn[0] <= '0;
		ovf_sn[0] <= UW'(num) >= (UW'(den) << W);
		neg_sn[0] <= neg;
		clr_sn[0] <= clr;
	end

	for (genvar k = 1; k <= W; k++) begin : g_bit
		localparam int B = W - k;
		logic [UW-1:0] dsh;
		logic          ge;

		assign dsh = UW'(den_sn[k-1]) << B;
		assign ge  = UW'(rem_sn[k-1]) >= dsh;

		always_ff @(posedge clk) begin
			rem_sn[k] <= ge ? NW'(UW'(rem_sn[k-1]) - dsh) : rem_sn[k-1];
			den_sn[k] <= den_sn[k-1];
			quo_sn[k] <= quo_sn[k-1] | (W'(ge) << B);
			ovf_sn[k] <= ovf_sn[k-1];
			neg_sn[k] <= neg_sn[k-1];
			clr_sn[k] <= clr_sn[k-1];
		end
	end

	always_comb begin
		mag = quo_sn[W];
		if (clr_sn[W]) begin
			res = '0;
		end else if (ovf_sn[W]) begin
			res = neg_sn[W] ? MINV : MAXV;
		end else if (!neg_sn[W]) begin
			res = mag[W-1] ? MAXV : mag;
		end else begin
			res = (mag > MINV) ? MINV : (~mag + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		quo <= res;
	end

endmodule

>>> rtl/affine_inverse_3x4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_inverse_3x4
// Inverse of a 3x4 affine transform, one inverse row per cycle.
// ----------------------------------------------------------------------------
// Path: a row passes the input register, cofactor, dot and division stages;
// row 0 is strobed first, then rows 1 and 2 in consecutive cycles.
// Throughput: a new word once busy drops; the input register issues one row a
// cycle into the shared product and 4-way division pipe (one bit a stage).
// Reset clears the row sequencer and all valid bits; results cannot be held.
// ----------------------------------------------------------------------------
module affine_inverse_3x4 #(
	parameter int COEF_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COEF_WIDTH-1:0] lin_r0_c0,
	input  logic signed [COEF_WIDTH-1:0] lin_r1_c0,
	input  logic signed [COEF_WIDTH-1:0] lin_r2_c0,
	input  logic signed [COEF_WIDTH-1:0] lin_r0_c1,
	input  logic signed [COEF_WIDTH-1:0] lin_r1_c1,
	input  logic signed [COEF_WIDTH-1:0] lin_r2_c1,
	input  logic signed [COEF_WIDTH-1:0] lin_r0_c2,
	input  logic signed [COEF_WIDTH-1:0] lin_r1_c2,
	input  logic signed [COEF_WIDTH-1:0] lin_r2_c2,
	input  logic signed [COEF_WIDTH-1:0] shift_x,
	input  logic signed [COEF_WIDTH-1:0] shift_y,
	input  logic signed [COEF_WIDTH-1:0] shift_z,
	output logic                         done,
	output logic [1:0]                   row_index,
	output logic signed [COEF_WIDTH-1:0] inv_c0,
	output logic signed [COEF_WIDTH-1:0] inv_c1,
	output logic signed [COEF_WIDTH-1:0] inv_c2,
	output logic signed [COEF_WIDTH-1:0] inv_shift,
	output logic                         singular,
	output logic                         last
);

	localparam int W   = COEF_WIDTH;
	localparam int DW  = 3*W + 2;
	localparam int NW  = 3*W + 3 + 2*FRAC_BITS;
	localparam int DLY = W + 2;

	logic signed [W-1:0] m_s1 [3][3];
	logic signed [W-1:0] t_s1 [3];
	logic                vld_q;
	logic [1:0]          row_q;
	logic                accept;
	aff_pkg::side_t      side_s1, side_c, side_d;
	aff_pkg::side_t      side_dly [DLY];

	logic signed [2*W:0] adj [3];
	logic signed [W-1:0] mcol [3];
	logic signed [W-1:0] tv [3];
	logic [NW-1:0]       num [4];
	logic                qneg [4];
	logic [DW-1:0]       den;
	logic signed [W-1:0] quo [4];

	assign busy   = vld_q && (row_q != aff_pkg::ROW_LAST);
	assign accept = start && !busy;

	always_ff @(posedge clk) begin
		if (accept) begin
			m_s1[0][0] <= lin_r0_c0;
			m_s1[1][0] <= lin_r1_c0;
			m_s1[2][0] <= lin_r2_c0;
			m_s1[0][1] <= lin_r0_c1;
			m_s1[1][1] <= lin_r1_c1;
			m_s1[2][1] <= lin_r2_c1;
			m_s1[0][2] <= lin_r0_c2;
			m_s1[1][2] <= lin_r1_c2;
			m_s1[2][2] <= lin_r2_c2;
			t_s1[0]    <= shift_x;
			t_s1[1]    <= shift_y;
			t_s1[2]    <= shift_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			row_q <= aff_pkg::ROW_FIRST;
		end else if (accept) begin
			vld_q <= 1'b1;
			row_q <= aff_pkg::ROW_FIRST;
		end else if (vld_q) begin
			if (row_q == aff_pkg::ROW_LAST) begin
				vld_q <= 1'b0;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_comb begin
		side_s1.vld  = vld_q;
		side_s1.row  = row_q;
		side_s1.sing = 1'b0;
	end

	aff_cof #(.W(W)) u_cof (
		.clk    (clk),
		.arst_n (arst_n),
		.side_i (side_s1),
		.m      (m_s1),
		.t      (t_s1),
		.side_o (side_c),
		.adj_o  (adj),
		.mcol_o (mcol),
		.t_o    (tv)
	);

	aff_dot #(.W(W), .F(FRAC_BITS), .DW(DW), .NW(NW)) u_dot (
		.clk    (clk),
		.arst_n (arst_n),
		.side_i (side_c),
		.adj    (adj),
		.mcol   (mcol),
		.t      (tv),
		.side_o (side_d),
		.num_o  (num),
		.neg_o  (qneg),
		.den_o  (den)
	);

	for (genvar k = 0; k < 4; k++) begin : g_div
		aff_div #(.W(W), .NW(NW), .DW(DW)) u_div (
			.clk (clk),
			.num (num[k]),
			.den (den),
			.neg (qneg[k]),
			.clr (side_d.sing),
			.quo (quo[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DLY; i++) begin
				side_dly[i] <= '0;
			end
		end else begin
			side_dly[0] <= side_d;
			for (int i = 1; i < DLY; i++) begin
				side_dly[i] <= side_dly[i-1];
			end
		end
	end

	assign done      = side_dly[DLY-1].vld;
	assign row_index = side_dly[DLY-1].row;
	assign singular  = side_dly[DLY-1].sing;
	assign last      = (side_dly[DLY-1].row == aff_pkg::ROW_LAST);
	assign inv_c0    = quo[0];
	assign inv_c1    = quo[1];
	assign inv_c2    = quo[2];
	assign inv_shift = quo[3];

endmodule

>>> rtl/aff_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aff_chk
// Port-level checks on row ordering, busy and the per-word flags.
// ----------------------------------------------------------------------------
module aff_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] row_index,
	input logic       singular,
	input logic       last
);

	a_row01: assert property (@(posedge clk) disable iff (!arst_n)
		done && (row_index == 2'd0) |=> done && (row_index == 2'd1))
		else $error("row 1 does not follow row 0");

	a_row12: assert property (@(posedge clk) disable iff (!arst_n)
		done && (row_index == 2'd1) |=> done && (row_index == 2'd2))
		else $error("row 2 does not follow row 1");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (last == (row_index == 2'd2)))
		else $error("last flag out of step with row");

	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		done && (row_index != 2'd0) |-> (singular == $past(singular)))
		else $error("singular flag changed within a word");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

endmodule

bind affine_inverse_3x4 aff_chk u_aff_chk (.*);
